// ----- hdl/owf_pkg.sv -----
// Package for the overlapping window framer: shared types, register map and codes.
// No dependencies; every other file in hdl/ imports it.
package owf_pkg;

	localparam int SEG_W     = 7;
	localparam int POS_W     = 6;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [SEG_W-1:0] SEG_RESET = 7'd64;
	localparam logic [SEG_W-1:0] HOP_RESET = 7'd32;

	typedef enum logic [1:0] {
		REG_SEGMENT  = 2'd0,
		REG_HOP      = 2'd1,
		REG_PASS_RAW = 2'd2
	} reg_idx_t;

	localparam logic KIND_WINDOW = 1'b0;
	localparam logic KIND_RAW    = 1'b1;

	localparam logic MODE_PUSH  = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// Effective (clamped) configuration seen by the datapath.
	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic [SEG_W-1:0] hop;
		logic             pass_raw;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;
		logic clear;
		logic load_raw;
		logic start_win;
		logic load_win;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic raw_ok;
		logic win_due;
		logic win_last;
		logic slot_free;
	} dp_status_t;

endpackage

// ----- hdl/owf_ifs.sv -----
// Stream interfaces for the overlapping window framer: input items and result items.
// Depends on owf_pkg for the position width.
interface owf_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source(output valid, mode, sample_in, input ready);
	modport sink(input valid, mode, sample_in, output ready);
endinterface

interface owf_out_if #(parameter int SAMPLE_BITS = 16);
	import owf_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [POS_W-1:0]              position;
	logic                          last;

	modport source(output valid, kind, sample_out, position, last, input ready);
	modport sink(input valid, kind, sample_out, position, last, output ready);
endinterface

// ----- hdl/overlapping_window_framer_top.sv -----
// Top level of the overlapping window framer: APB registers, controller and datapath.
// Depends on owf_pkg, owf_ifs (owf_in_if, owf_out_if), owf_regs, owf_ctrl and owf_dp.
//
// The framer takes signed PCM samples one transaction at a time and writes each into a
// ring memory of RING_DEPTH entries. Whenever strictly more than segment_size samples are
// buffered between the window start and the write pointer, it emits a window of
// segment_size samples starting at the window start, numbered by position with the final
// one marked last, and then moves the window start forward by hop_size. With pass_raw set,
// each pushed sample is echoed first as a raw result (kind 1, position 0, last 1); that
// echo is dropped when a window is due and the echo plus the window would exceed
// MAX_SEGMENT results. A clear transaction discards the buffered samples by moving the
// window start to the write pointer and produces no result. Segment size is clamped to
// 1..MAX_SEGMENT and hop to 1..segment. Registers: segment_size at byte 0, hop_size at
// byte 4, pass_raw at byte 8; they must only be written while the framer is idle.
// A clear is handled at acceptance. A push passes through accept, raw echo decision and
// window check; each due window adds a start step and the readout of its samples, and
// the result side can stall the echo and the readout. Window readout streams one sample per
// cycle through the single, registered read port of the ring memory unless results stall.
// The block works on one input transaction at a time; the output register lets the next
// input be accepted while the last result still waits. Ring contents need no clearing
// after reset, since only samples written since reset or the last clear are ever read.
module overlapping_window_framer_top #(
	parameter int RING_DEPTH  = 128,
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_SEGMENT = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [owf_pkg::PADDR_W-1:0] paddr,
	input  logic [owf_pkg::PDATA_W-1:0] pwdata,
	output logic [owf_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	owf_in_if.sink                      samples,
	owf_out_if.source                   results
);
	import owf_pkg::*;

	cfg_t                          cfg;
	ctl_cmd_t                      cmd;
	dp_status_t                    status;
	logic                          out_valid;
	logic                          out_kind;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic [POS_W-1:0]              out_pos;
	logic                          out_last;
	logic                          in_ready;

	// Configuration registers; the datapath only ever sees the clamped values.
	owf_regs #(
		.MAX_SEGMENT(MAX_SEGMENT)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The controller accepts input transactions only from its idle state and walks
	// through the raw echo and any due windows before returning there.
	owf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_mode  (samples.mode),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the ring memory, the pointers, the per-transaction result
	// budget and the output register that drives the result channel.
	owf_dp #(
		.RING_DEPTH  (RING_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_SEGMENT (MAX_SEGMENT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.in_sample  (samples.sample_in),
		.status     (status),
		.out_ready  (results.ready),
		.out_valid  (out_valid),
		.out_kind   (out_kind),
		.out_sample (out_sample),
		.out_pos    (out_pos),
		.out_last   (out_last)
	);

	assign samples.ready      = in_ready;
	assign results.valid      = out_valid;
	assign results.kind       = out_kind;
	assign results.sample_out = out_sample;
	assign results.position   = out_pos;
	assign results.last       = out_last;

endmodule

// ----- hdl/owf_regs.sv -----
// APB configuration registers of the framer, with clamping of segment and hop.
// Depends on owf_pkg.
module owf_regs #(
	parameter int MAX_SEGMENT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [owf_pkg::PADDR_W-1:0]   paddr,
	input  logic [owf_pkg::PDATA_W-1:0]   pwdata,
	output logic [owf_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output owf_pkg::cfg_t                 cfg
);
	import owf_pkg::*;

	logic [SEG_W-1:0] seg_q;
	logic [SEG_W-1:0] hop_q;
	logic             pass_raw_q;
	logic [SEG_W-1:0] seg_eff;
	logic             wr_en;
	reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q      <= SEG_RESET;
			hop_q      <= HOP_RESET;
			pass_raw_q <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_SEGMENT:  seg_q      <= pwdata[SEG_W-1:0];
				REG_HOP:      hop_q      <= pwdata[SEG_W-1:0];
				REG_PASS_RAW: pass_raw_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_SEGMENT:  prdata = PDATA_W'(seg_q);
			REG_HOP:      prdata = PDATA_W'(hop_q);
			REG_PASS_RAW: prdata = PDATA_W'(pass_raw_q);
			default:      prdata = '0;
		endcase
	end

	// Segment is held to 1..MAX_SEGMENT, hop to 1..segment.
	always_comb begin
		if (seg_q == '0) begin
			seg_eff = SEG_W'(1);
		end else if (seg_q > SEG_W'(MAX_SEGMENT)) begin
			seg_eff = SEG_W'(MAX_SEGMENT);
		end else begin
			seg_eff = seg_q;
		end
		cfg.seg      = seg_eff;
		cfg.pass_raw = pass_raw_q;
		if (hop_q == '0) begin
			cfg.hop = SEG_W'(1);
		end else if (hop_q > seg_eff) begin
			cfg.hop = seg_eff;
		end else begin
			cfg.hop = hop_q;
		end
	end

endmodule

// ----- hdl/owf_ctrl.sv -----
// Controller state machine of the framer: sequences push, raw echo and window readout.
// Depends on owf_pkg for the command and status structs.
module owf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_mode,
	output logic                in_ready,
	input  owf_pkg::dp_status_t status,
	output owf_pkg::ctl_cmd_t   cmd
);
	import owf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RAW   = 4'b0010,
		S_CHECK = 4'b0100,
		S_LOAD  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_mode == MODE_CLEAR) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.push = 1'b1;
						state_d  = S_RAW;
					end
				end
			end
			S_RAW: begin
				if (status.raw_ok) begin
					if (status.slot_free) begin
						cmd.load_raw = 1'b1;
						state_d      = S_CHECK;
					end
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.win_due) begin
					cmd.start_win = 1'b1;
					state_d       = S_LOAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LOAD: begin
				if (status.slot_free) begin
					cmd.load_win = 1'b1;
					if (status.win_last) begin
						state_d = S_CHECK;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- hdl/owf_dp.sv -----
// Datapath of the framer: ring memory, write and window pointers, result budget, output register.
// Depends on owf_pkg; driven by owf_ctrl commands.
module owf_dp #(
	parameter int RING_DEPTH  = 128,
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_SEGMENT = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  owf_pkg::cfg_t                      cfg,
	input  owf_pkg::ctl_cmd_t                  cmd,
	input  logic signed [SAMPLE_BITS-1:0]      in_sample,
	output owf_pkg::dp_status_t                status,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic                               out_kind,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	output logic [owf_pkg::POS_W-1:0]          out_pos,
	output logic                               out_last
);
	import owf_pkg::*;

	localparam int AW    = $clog2(RING_DEPTH);
	localparam int AW1   = AW + 1;
	localparam int CW    = (AW > SEG_W) ? AW : SEG_W;
	localparam int CNT_W = $clog2(MAX_SEGMENT + 1);
	localparam int SUM_W = SEG_W + 1;

	logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [AW-1:0]          wr_idx_q;
	logic [AW-1:0]          win_start_q;
	logic [AW-1:0]          rd_ptr_q;
	logic [POS_W-1:0]       pos_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	logic                   out_kind_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic [POS_W-1:0]       out_pos_q;
	logic                   out_last_q;

	logic [AW1-1:0]         buf_diff;
	logic [AW-1:0]          buffered;
	logic                   due;
	logic [AW1-1:0]         hop_sum;
	logic [AW-1:0]          next_start;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   slot_free;
	logic                   win_last;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
		return (x == AW'(RING_DEPTH - 1)) ? '0 : x + AW'(1);
	endfunction

	// Occupancy of the ring between window start and write pointer.
	always_comb begin
		buf_diff = AW1'(wr_idx_q) - AW1'(win_start_q);
		if (wr_idx_q < win_start_q) begin
			buf_diff = buf_diff + AW1'(RING_DEPTH);
		end
		buffered = buf_diff[AW-1:0];
		due      = CW'(buffered) > CW'(cfg.seg);
	end

	always_comb begin
		hop_sum = AW1'(win_start_q) + AW1'(cfg.hop);
		if (hop_sum >= AW1'(RING_DEPTH)) begin
			hop_sum = hop_sum - AW1'(RING_DEPTH);
		end
		next_start = hop_sum[AW-1:0];
	end

	assign slot_free = !out_valid_q || out_ready;
	assign win_last  = (SEG_W'(pos_q) == cfg.seg - SEG_W'(1));
	assign rd_en     = cmd.start_win || (cmd.load_win && !win_last);
	assign rd_addr   = cmd.start_win ? win_start_q : rd_ptr_q;

	assign status.slot_free = slot_free;
	assign status.win_last  = win_last;
	assign status.raw_ok    = cfg.pass_raw &&
		(!due || (SUM_W'(cfg.seg) + SUM_W'(1) <= SUM_W'(MAX_SEGMENT)));
	assign status.win_due   = due &&
		(SUM_W'(count_q) + SUM_W'(cfg.seg) <= SUM_W'(MAX_SEGMENT));

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_idx_q] <= in_sample;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			win_start_q <= '0;
			rd_ptr_q    <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				wr_idx_q <= wrap_inc(wr_idx_q);
				count_q  <= '0;
			end
			if (cmd.clear) begin
				win_start_q <= wr_idx_q;
			end
			if (cmd.load_raw) begin
				count_q <= CNT_W'(1);
			end
			if (cmd.start_win) begin
				rd_ptr_q <= wrap_inc(win_start_q);
				pos_q    <= '0;
			end
			if (cmd.load_win) begin
				if (win_last) begin
					win_start_q <= next_start;
					count_q     <= CNT_W'(SUM_W'(count_q) + SUM_W'(cfg.seg));
				end else begin
					rd_ptr_q <= wrap_inc(rd_ptr_q);
					pos_q    <= pos_q + POS_W'(1);
				end
			end
			if (cmd.load_raw || cmd.load_win) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_raw) begin
			out_kind_q   <= KIND_RAW;
			out_sample_q <= sample_q;
			out_pos_q    <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.load_win) begin
			out_kind_q   <= KIND_WINDOW;
			out_sample_q <= rd_data_q;
			out_pos_q    <= pos_q;
			out_last_q   <= win_last;
		end
		if (cmd.push) begin
			sample_q <= in_sample;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_sample = out_sample_q;
	assign out_pos    = out_pos_q;
	assign out_last   = out_last_q;

`ifndef ASSERT_OFF
	a_raw_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_RAW) |-> (out_pos_q == '0 && out_last_q))
		else $error("raw echo must have position zero and last set");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_WINDOW) |-> (SEG_W'(out_pos_q) < cfg.seg))
		else $error("window position beyond segment size");

	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_raw || cmd.load_win) |-> slot_free)
		else $error("output register overwritten while a result is pending");

	a_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_win && win_last) |=> (count_q <= CNT_W'(MAX_SEGMENT)))
		else $error("result budget exceeded for one input item");
`endif

endmodule
